// ===== sv/fvc_pkg.sv =====
package fvc_pkg;

	localparam int MAX_TAPS = 16;
	localparam int DATA_W   = 32;
	localparam int TAP_W    = $clog2(MAX_TAPS);
	localparam int CNT_W    = $clog2(MAX_TAPS + 1);
	localparam int CFG_W    = 5;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [TAP_W-1:0]         tap_idx_t;
	typedef logic [CFG_W-1:0]         cfg_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic {
		CMD_COEF = 1'b0,
		CMD_PUSH = 1'b1
	} cmd_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic shift;
		logic coef_we;
		logic tap_en;
		logic tok_in;
	} cell_ctrl_t;

endpackage

// ===== sv/fvc_ifs.sv =====
interface fvc_item_if;
	logic             valid;
	logic             ready;
	fvc_pkg::cmd_t    cmd;
	fvc_pkg::tap_idx_t tap_slot;
	fvc_pkg::data_t   data_value;

	modport source (output valid, output cmd, output tap_slot, output data_value, input ready);
	modport sink   (input valid, input cmd, input tap_slot, input data_value, output ready);
endinterface

interface fvc_result_if;
	logic           valid;
	logic           ready;
	fvc_pkg::data_t filter_sum;

	modport source (output valid, output filter_sum, input ready);
	modport sink   (input valid, input filter_sum, output ready);
endinterface

interface fvc_cfg_if;
	logic          valid;
	logic          ready;
	fvc_pkg::cfg_t tap_count;

	modport source (output valid, output tap_count, input ready);
	modport sink   (input valid, input tap_count, output ready);
endinterface

// ===== sv/fvc_cell.sv =====
module fvc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fvc_pkg::cell_ctrl_t ctrl,
	input  fvc_pkg::data_t      hist_in,
	input  fvc_pkg::data_t      coef_in,
	input  fvc_pkg::data_t      psum_in,
	output fvc_pkg::data_t      hist_out,
	output fvc_pkg::data_t      psum_out,
	output logic                tok_out
);
	import fvc_pkg::*;

	data_t              hist_q;
	data_t              coef_q;
	data_t              prod_q;
	data_t              psum_q;
	logic               tok_q;
	data_t              mul_w;

	// low half of the product is the same for signed and unsigned operands
	assign mul_w = hist_q * coef_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			hist_q <= hist_in;
		end
		if (ctrl.coef_we) begin
			coef_q <= coef_in;
		end
		// taps beyond the active count contribute nothing
		prod_q <= ctrl.tap_en ? mul_w : '0;
		if (ctrl.tok_in) begin
			psum_q <= psum_in + prod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= ctrl.tok_in;
		end
	end

	assign hist_out = hist_q;
	assign psum_out = psum_q;
	assign tok_out  = tok_q;

endmodule

// ===== sv/fir_valid_convolution.sv =====
// pipeline: a sample that completes a window shifts the history (s1), registers the
// products (s2), passes the sum token through the 16 cells, then the output register
// flow: the next item waits until that single sum token has left the chain and the
// result has transferred; a coefficient write or a sample with no result holds nothing off
// reset: arst_n clears the sample count, the sum tokens and the output flag; tap_count -> 16
module fir_valid_convolution (
	input  logic   clk,
	input  logic   arst_n,
	fvc_item_if.sink     items,
	fvc_result_if.source results,
	fvc_cfg_if.sink      cfg
);
	import fvc_pkg::*;

	cfg_t               tap_count_q;
	cnt_t               seen_q;
	cnt_t               seen_nxt;
	cnt_t               eff_taps;
	logic               start_s1;
	logic               start_s2;
	logic               out_valid_q;
	data_t              out_data_q;
	logic               item_xfer;
	logic               push_xfer;
	logic               coef_xfer;
	logic               emit;
	logic               busy;

	cell_ctrl_t         ctrl_w [MAX_TAPS];
	data_t              hist_w [MAX_TAPS];
	data_t              psum_w [MAX_TAPS];
	logic [MAX_TAPS-1:0] tok_w;

	// configuration port: always ready, register written on any transfer
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CFG_W'(MAX_TAPS);
		end else if (cfg.valid && cfg.ready) begin
			tap_count_q <= cfg.tap_count;
		end
	end

	// zero counts as one tap, anything above the built size clamps to it
	always_comb begin
		if (tap_count_q == '0) begin
			eff_taps = CNT_W'(1);
		end else if (CNT_W'(tap_count_q) > CNT_W'(MAX_TAPS)) begin
			eff_taps = CNT_W'(MAX_TAPS);
		end else begin
			eff_taps = CNT_W'(tap_count_q);
		end
	end

	// one item in flight at a time; result register must be drained first
	assign busy        = start_s1 || start_s2 || (|tok_w) || out_valid_q;
	assign items.ready = !busy;
	assign item_xfer   = items.valid && items.ready;
	assign push_xfer   = item_xfer && (items.cmd == CMD_PUSH);
	assign coef_xfer   = item_xfer && (items.cmd == CMD_COEF);

	// saturating sample count
	assign seen_nxt = (seen_q == CNT_W'(MAX_TAPS)) ? seen_q : seen_q + CNT_W'(1);
	assign emit     = push_xfer && (seen_nxt >= eff_taps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			start_s1 <= 1'b0;
			start_s2 <= 1'b0;
		end else begin
			if (push_xfer) begin
				seen_q <= seen_nxt;
			end
			// s1: history shifted, s2: products registered, then token enters cell 0
			start_s1 <= emit;
			start_s2 <= start_s1;
		end
	end

	// the row of cells: history shifts towards higher taps, partial sum rides the token
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		always_comb begin
			ctrl_w[k].shift   = push_xfer;
			ctrl_w[k].coef_we = coef_xfer && (items.tap_slot == TAP_W'(k));
			ctrl_w[k].tap_en  = CNT_W'(k) < eff_taps;
			ctrl_w[k].tok_in  = (k == 0) ? start_s2 : tok_w[(k == 0) ? 0 : k-1];
		end

		fvc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl_w[k]),
			.hist_in  ((k == 0) ? items.data_value : hist_w[(k == 0) ? 0 : k-1]),
			.coef_in  (items.data_value),
			.psum_in  ((k == 0) ? data_t'(0) : psum_w[(k == 0) ? 0 : k-1]),
			.hist_out (hist_w[k]),
			.psum_out (psum_w[k]),
			.tok_out  (tok_w[k])
		);
	end

	// output register, holds the sum until the result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_w[MAX_TAPS-1]) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_w[MAX_TAPS-1]) begin
			out_data_q <= psum_w[MAX_TAPS-1];
		end
	end

	assign results.valid      = out_valid_q;
	assign results.filter_sum = out_data_q;

	// at most one sum in flight anywhere in the sequencer and chain
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_s1, start_s2, tok_w}))
		else $error("more than one sum in flight");

	// a pending result means the chain has gone quiet
	a_out_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (tok_w == '0) && !start_s1 && !start_s2)
		else $error("result pending while chain busy");

	// a completing push launches the sum
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> start_s1 ##1 start_s2)
		else $error("sum not launched after full window");

	// the result flag rises only when the token leaves the last cell
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tok_w[MAX_TAPS-1]))
		else $error("result without token");

endmodule

// ===== dv/fir_valid_convolution_test.sv =====
`timescale 1ns / 100ps

module fir_valid_convolution_test;
	import fvc_pkg::*;

	// cycles without any transfer before the run is abandoned
	localparam int WATCHDOG_LIMIT = 4000;
	// settling time after the last owed sum has come back
	localparam int SETTLE_CYCLES  = 40;
	// long output hold-off, well past the depth of the pipeline
	localparam int HOLD_OFF       = 400;
	localparam int PHASE_ITEMS    = 38;

	logic clk;
	logic arst_n;

	fvc_item_if   item_ch ();
	fvc_result_if sum_ch ();
	fvc_cfg_if    cfg_ch ();

	fir_valid_convolution dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (sum_ch),
		.cfg     (cfg_ch)
	);

	// filter state as the block should hold it
	data_t history_model [MAX_TAPS];
	data_t coeff_model [MAX_TAPS];
	int    samples_seen_model = 0;
	cfg_t  tap_setting_model  = cfg_t'(MAX_TAPS);

	// sums still owed by the block, oldest first
	data_t expected_sums [$];

	int error_count  = 0;
	int quiet_cycles = 0;

	// sender burst state
	int burst_left = 0;
	bit no_gaps    = 1'b0;

	// receiver stall state
	int       hold_request = 0;
	int       hold_left    = 0;
	int       pattern_age  = 0;
	int       stall_pos    = 0;
	bit [7:0] ready_pattern = 8'hFF;

	data_t extreme_values [5] = '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(string what);
		$display("ERROR at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// a zero setting behaves as one tap, anything past the store as all taps
	function automatic int active_taps(cfg_t setting);
		if (setting == 0)
			return 1;
		if (setting > MAX_TAPS)
			return MAX_TAPS;
		return int'(setting);
	endfunction

	// mostly full-range values, with the extremes and small numbers mixed in
	function automatic data_t random_value();
		case ($urandom_range(0, 9))
			0: return extreme_values[$urandom_range(0, 4)];
			1: return data_t'($urandom_range(0, 255)) - 32'sd128;
			default: return data_t'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// prediction: mirror every item transfer into the filter state
	// ---------------------------------------------------------------
	always @(posedge clk) begin : item_model
		logic [DATA_W-1:0] acc;
		int taps;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			if (item_ch.cmd == CMD_COEF) begin
				coeff_model[item_ch.tap_slot] = item_ch.data_value;
			end else begin
				// the history always keeps the last full window, whatever the tap count
				for (int k = MAX_TAPS - 1; k > 0; k--)
					history_model[k] = history_model[k - 1];
				history_model[0] = item_ch.data_value;
				if (samples_seen_model < MAX_TAPS)
					samples_seen_model++;
				taps = active_taps(tap_setting_model);
				// no sum until the window is full
				if (samples_seen_model >= taps) begin
					acc = '0;
					for (int k = 0; k < taps; k++)
						acc = acc + history_model[k] * coeff_model[k];
					expected_sums.push_back(data_t'(acc));
				end
			end
		end
	end

	// a new tap count takes effect from the next sample
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			tap_setting_model = cfg_ch.tap_count;
	end

	// ---------------------------------------------------------------
	// checking: each result transfer against the oldest owed sum
	// ---------------------------------------------------------------
	always @(posedge clk) begin : sum_checker
		data_t want;
		if (arst_n && sum_ch.valid && sum_ch.ready) begin
			if (expected_sums.size() == 0) begin
				report_error($sformatf("unexpected filter_sum %0d", sum_ch.filter_sum));
			end else begin
				want = expected_sums.pop_front();
				if (sum_ch.filter_sum !== want)
					report_error($sformatf("filter_sum %0d, wanted %0d",
						sum_ch.filter_sum, want));
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: rotating stall pattern, reloaded now and then, with an
	// occasional long hold-off asked for by a test
	// ---------------------------------------------------------------
	always @(posedge clk) begin : sum_ready_pattern
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			sum_ch.ready <= 1'b0;
		end else begin
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(24, 64);
				case ($urandom_range(0, 3))
					0: ready_pattern = 8'hFF;                               // full rate
					1: ready_pattern = 8'h01 << $urandom_range(0, 7);      // mostly stalled
					default: ready_pattern = 8'($urandom) | 8'h01;
				endcase
			end
			pattern_age--;
			stall_pos++;
			sum_ch.ready <= ready_pattern[stall_pos % 8];
		end
	end

	// ---------------------------------------------------------------
	// watchdog: too long without any transfer means the block is stuck
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (sum_ch.valid && sum_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sender: offer one item and hold it until the transfer; valid stays
	// high across a burst and drops for the random gap after it
	// ---------------------------------------------------------------
	task automatic send_item(cmd_t cmd, tap_idx_t slot, data_t value);
		int gap;
		item_ch.cmd        <= cmd;
		item_ch.tap_slot   <= slot;
		item_ch.data_value <= value;
		item_ch.valid      <= 1'b1;
		do
			@(posedge clk);
		while (!item_ch.ready);
		if (burst_left > 0 || no_gaps) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic stop_items();
		item_ch.valid <= 1'b0;
	endtask

	// every owed sum back, then the settling time
	task automatic wait_drained();
		@(posedge clk);
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// tap count is only changed with the block idle
	task automatic write_tap_count(cfg_t setting);
		stop_items();
		wait_drained();
		cfg_ch.tap_count <= setting;
		cfg_ch.valid     <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// every coefficient written before any window can read it, extremes first
	task automatic test_coeff_load();
		for (int slot = 0; slot < MAX_TAPS; slot++)
			send_item(CMD_COEF, tap_idx_t'(slot),
				(slot < 5) ? extreme_values[slot] : data_t'($urandom));
	endtask

	// reset tap count is the full window: these samples give no sum yet
	task automatic test_window_fill();
		foreach (extreme_values[i])
			send_item(CMD_PUSH, tap_idx_t'($urandom), extreme_values[i]);
		send_item(CMD_PUSH, tap_idx_t'($urandom), data_t'($urandom));
	endtask

	// zero acts as one tap; a count past the store acts as the full window
	task automatic test_tap_count_limits();
		write_tap_count(cfg_t'(0));
		send_item(CMD_PUSH, 4'hF, 32'sh7FFF_FFFF);
		send_item(CMD_PUSH, 4'h0, 32'sh8000_0000);
		write_tap_count(cfg_t'(31));
		send_item(CMD_PUSH, 4'hA, -32'sd1);
		send_item(CMD_PUSH, 4'h5, data_t'($urandom));
	endtask

	// output held off for a long stretch while samples keep coming, so the
	// block fills and stalls its input
	task automatic test_output_backpressure();
		write_tap_count(cfg_t'(3));
		no_gaps = 1'b1;
		hold_request = HOLD_OFF;
		repeat (48)
			send_item(CMD_PUSH, tap_idx_t'($urandom), random_value());
		no_gaps = 1'b0;
	endtask

	// random samples and coefficient rewrites through a run of tap counts
	task automatic test_random_stream();
		cfg_t settings [10] = '{5'd1, 5'd16, 5'd2, 5'd17, 5'd31, 5'd0, 5'd8, 5'd15,
			5'd4, 5'd1};
		settings[9] = cfg_t'($urandom_range(1, MAX_TAPS));
		foreach (settings[p]) begin
			write_tap_count(settings[p]);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					send_item(CMD_COEF, tap_idx_t'($urandom), random_value());
				else
					send_item(CMD_PUSH, tap_idx_t'($urandom), random_value());
			end
		end
	endtask

	initial begin
		// all inputs known from the start
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.cmd        = CMD_COEF;
		item_ch.tap_slot   = '0;
		item_ch.data_value = '0;
		sum_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.tap_count   = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_coeff_load();
		test_window_fill();
		test_tap_count_limits();
		test_output_backpressure();
		test_random_stream();

		// drain the last sums and let the pipeline settle
		stop_items();
		wait_drained();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
